[sv/plc_pkg.sv]
// Shared constants and types for the pen line clipper.
// Holds widths, operation, status and register codes, register reset values and the divider status struct.
// No dependencies.
package plc_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 16;

   // register index width on the configuration channel
   localparam int CSR_ADDR_BITS = 4;

   // operation codes
   localparam logic [1:0] OP_MOVE_ABS = 2'd0;
   localparam logic [1:0] OP_MOVE_REL = 2'd1;
   localparam logic [1:0] OP_DRAW_ABS = 2'd2;
   localparam logic [1:0] OP_DRAW_REL = 2'd3;

   // clip status codes
   localparam logic [1:0] STATUS_UNCLIPPED = 2'd0;
   localparam logic [1:0] STATUS_PARTLY    = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_CLIP_LEFT   = 4'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CLIP_RIGHT  = 4'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CLIP_TOP    = 4'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CLIP_BOTTOM = 4'd3;

   // register reset values
   localparam int CLIP_LEFT_RST   = 0;
   localparam int CLIP_RIGHT_RST  = 1023;
   localparam int CLIP_TOP_RST    = 0;
   localparam int CLIP_BOTTOM_RST = 1023;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[sv/plc_if.sv]
// Channel interfaces of the pen line clipper: request, response and register write.
// Depends on plc_pkg for the default coordinate width and register index width.
interface plc_req_if #(
   parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;

   modport source (output valid, operation, coord_x, coord_y, input ready);
   modport sink   (input valid, operation, coord_x, coord_y, output ready);
endinterface

interface plc_rsp_if #(
   parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         draw_valid;
   logic [1:0]                   clip_status;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, draw_valid, clip_status, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink   (input valid, draw_valid, clip_status, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

interface plc_csr_if #(
   parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic [plc_pkg::CSR_ADDR_BITS-1:0]  index;
   logic [COORD_BITS-1:0]              data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/plc_divider.sv]
// Radix-2 restoring signed divider, quotient truncated toward zero.
// One quotient bit per cycle; depends on plc_pkg for the status struct.
module plc_divider #(
   parameter int NUM_BITS = 2 * plc_pkg::COORD_BITS_DEF + 3,
   parameter int DEN_BITS = plc_pkg::COORD_BITS_DEF + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] dividend,
   input  logic signed [DEN_BITS-1:0] divisor,
   output plc_pkg::div_status_type    status,
   output logic signed [NUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;

   logic [DEN_BITS:0]   rem_sh;
   logic [DEN_BITS:0]   rem_sub;
   logic                fits;

   // one restoring step
   assign rem_sh  = {rem_ff, num_ff[NUM_BITS-1]};
   assign fits    = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         num_in  = dividend[NUM_BITS-1] ? NUM_BITS'(-dividend) : NUM_BITS'(dividend);
         den_in  = divisor[DEN_BITS-1] ? DEN_BITS'(-divisor) : DEN_BITS'(divisor);
         rem_in  = '0;
         neg_in  = dividend[NUM_BITS-1] ^ divisor[DEN_BITS-1];
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_BITS-2:0], fits};
         rem_in = fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // apply the sign to the magnitude
   assign quotient    = neg_ff ? -$signed(num_ff) : $signed(num_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_BITS'(1)) |=> done_ff)
      else $error("divider missed its done pulse");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

[sv/pen_line_clipper.sv]
// Pen line clipper top level: pen position, window registers, clipping sequencer.
// Depends on plc_pkg, the channel interfaces in plc_if and plc_divider.
//
//   channel    dir  payload                                           transfer
//   req_chan   in   operation, coord_x, coord_y                       valid && ready
//   rsp_chan   out  draw_valid, clip_status, start/end x and y        valid && ready
//   csr_chan   in   index, data (clip_left/right/top/bottom = 0..3)  valid && ready
//
// A move passes from the request transfer through the check and done states to the
// response register. A draw takes up to four solves, each a multiply, a rounding add
// and 2*COORD_BITS+3 steps of the shared divider. The request side is ready only while
// the sequencer is idle; a finished result waits in the response register until it is
// taken, and a further result holds the sequencer in its done state until the register is free.
// Reset is synchronous: pen goes to 0,0 and the window to its default.
module pen_line_clipper #(
   parameter int COORD_BITS = plc_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   plc_req_if.sink   req_chan,
   plc_rsp_if.source rsp_chan,
   plc_csr_if.sink   csr_chan
);

   localparam int W  = COORD_BITS;
   localparam int EW = W + 1;        // extents and differences
   localparam int PW = 2 * EW;       // products
   localparam int TW = PW + 1;       // product with rounding term
   localparam int VW = TW + 1;       // solved coordinate before it is checked

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_FX    = 4'd2;
   localparam logic [3:0] S_FY    = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_RND   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_TEST  = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic MODE_X = 1'b0;   // edge on x, solve for y
   localparam logic MODE_Y = 1'b1;   // edge on y, solve for x

   localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   // state
   logic [3:0]             state_ff, state_in;
   logic signed [W-1:0]    pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic signed [W-1:0]    clip_left_ff, clip_right_ff, clip_top_ff, clip_bottom_ff;
   logic [1:0]             op_ff, op_in;
   logic signed [W-1:0]    ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [EW-1:0]   ext_x_ff, ext_x_in, ext_y_ff, ext_y_in;
   logic [W-1:0]           rnd_x_ff, rnd_x_in, rnd_y_ff, rnd_y_in;
   logic signed [VW-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [W-1:0]    sv_ff, sv_in;
   logic                   mode_ff, mode_in;
   logic                   blk_ff, blk_in;
   logic                   depth_ff, depth_in;
   logic                   ep_ff, ep_in;
   logic                   clipped_ff, clipped_in;
   logic                   any_clip_ff, any_clip_in;
   logic signed [W-1:0]    fa_x_ff, fa_x_in, fa_y_ff, fa_y_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic                   res_draw_ff, res_draw_in;
   logic [1:0]             res_status_ff, res_status_in;
   logic signed [W-1:0]    res_sx_ff, res_sx_in, res_sy_ff, res_sy_in;
   logic signed [W-1:0]    res_ex_ff, res_ex_in, res_ey_ff, res_ey_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_draw_ff, rsp_draw_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic signed [W-1:0]    rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic signed [W-1:0]    rsp_ex_ff, rsp_ex_in, rsp_ey_ff, rsp_ey_in;

   // handshakes
   logic req_xfer, rsp_xfer, csr_xfer;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_chan.ready;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;

   // target position, relative offsets saturate
   logic                is_rel, is_draw;
   logic signed [EW-1:0] sum_x, sum_y;
   logic signed [W-1:0]  tx, ty;
   assign is_rel  = (req_chan.operation == plc_pkg::OP_MOVE_REL) ||
                    (req_chan.operation == plc_pkg::OP_DRAW_REL);
   assign is_draw = (op_ff == plc_pkg::OP_DRAW_ABS) || (op_ff == plc_pkg::OP_DRAW_REL);
   assign sum_x = EW'(pen_x_ff) + EW'(req_chan.coord_x);
   assign sum_y = EW'(pen_y_ff) + EW'(req_chan.coord_y);

   always_comb begin
      tx = req_chan.coord_x;
      ty = req_chan.coord_y;
      if (is_rel) begin
         if (sum_x[W] != sum_x[W-1]) tx = sum_x[W] ? COORD_MIN : COORD_MAX;
         else                        tx = sum_x[W-1:0];
         if (sum_y[W] != sum_y[W-1]) ty = sum_y[W] ? COORD_MIN : COORD_MAX;
         else                        ty = sum_y[W-1:0];
      end
   end

   // window tests on the working endpoint
   logic signed [VW-1:0] cl_w, cr_w, ct_w, cb_w;
   logic                 px_lt_l, px_gt_r, py_lt_t, py_gt_b, out_x, out_y;
   logic signed [W-1:0]  edge_x, edge_y;
   assign cl_w    = VW'(clip_left_ff);
   assign cr_w    = VW'(clip_right_ff);
   assign ct_w    = VW'(clip_top_ff);
   assign cb_w    = VW'(clip_bottom_ff);
   assign px_lt_l = px_ff < cl_w;
   assign px_gt_r = px_ff > cr_w;
   assign py_lt_t = py_ff < ct_w;
   assign py_gt_b = py_ff > cb_w;
   assign out_x   = px_lt_l || px_gt_r;
   assign out_y   = py_lt_t || py_gt_b;
   assign edge_x  = px_lt_l ? clip_left_ff : clip_right_ff;
   assign edge_y  = py_lt_t ? clip_top_ff : clip_bottom_ff;

   // trivial reject: both ends beyond one edge
   logic trivial_out;
   assign trivial_out = (ax_ff < clip_left_ff   && bx_ff < clip_left_ff)  ||
                        (ax_ff > clip_right_ff  && bx_ff > clip_right_ff) ||
                        (ay_ff < clip_top_ff    && by_ff < clip_top_ff)   ||
                        (ay_ff > clip_bottom_ff && by_ff > clip_bottom_ff);

   // segment set-up
   logic signed [EW-1:0] ext_x_new, ext_y_new;
   logic [EW-1:0]        mag_x, mag_y;
   assign ext_x_new = EW'(bx_ff) - EW'(ax_ff);
   assign ext_y_new = EW'(by_ff) - EW'(ay_ff);
   assign mag_x     = ext_x_new[EW-1] ? EW'(-ext_x_new) : EW'(ext_x_new);
   assign mag_y     = ext_y_new[EW-1] ? EW'(-ext_y_new) : EW'(ext_y_new);

   // operands of the current solve
   logic signed [W-1:0]  sol_v0, sol_w0;
   logic signed [EW-1:0] sol_dw, sol_dv, sol_diff;
   logic [W-1:0]         sol_r;
   logic signed [PW-1:0] sol_prod;
   logic signed [TW-1:0] sol_t;
   assign sol_v0   = (mode_ff == MODE_X) ? ax_ff : ay_ff;
   assign sol_w0   = (mode_ff == MODE_X) ? ay_ff : ax_ff;
   assign sol_dw   = (mode_ff == MODE_X) ? ext_y_ff : ext_x_ff;
   assign sol_dv   = (mode_ff == MODE_X) ? ext_x_ff : ext_y_ff;
   assign sol_r    = (mode_ff == MODE_X) ? rnd_x_ff : rnd_y_ff;
   assign sol_diff = EW'(sv_ff) - EW'(sol_v0);
   assign sol_prod = sol_dw * sol_diff;
   // rounding term takes the sign of the product
   assign sol_t    = prod_ff[PW-1] ? (TW'(prod_ff) - TW'($signed({1'b0, sol_r})))
                                   : (TW'(prod_ff) + TW'($signed({1'b0, sol_r})));

   // shared divider
   logic                    div_start;
   plc_pkg::div_status_type div_status;
   logic signed [TW-1:0]    div_q;
   logic signed [VW-1:0]    sol_res;
   assign div_start = (state_ff == S_RND);
   assign sol_res   = VW'(sol_w0) + VW'(div_q);

   plc_divider #(
      .NUM_BITS (TW),
      .DEN_BITS (EW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sol_t),
      .divisor  (sol_dv),
      .status   (div_status),
      .quotient (div_q)
   );

   // sequencer
   logic do_reject, test_y, test_out;
   assign test_y   = (blk_ff == depth_ff);
   assign test_out = test_y ? out_y : out_x;

   always_comb begin
      state_in      = state_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      op_in         = op_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      ext_x_in      = ext_x_ff;
      ext_y_in      = ext_y_ff;
      rnd_x_in      = rnd_x_ff;
      rnd_y_in      = rnd_y_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      sv_in         = sv_ff;
      mode_in       = mode_ff;
      blk_in        = blk_ff;
      depth_in      = depth_ff;
      ep_in         = ep_ff;
      clipped_in    = clipped_ff;
      any_clip_in   = any_clip_ff;
      fa_x_in       = fa_x_ff;
      fa_y_in       = fa_y_ff;
      prod_in       = prod_ff;
      res_draw_in   = res_draw_ff;
      res_status_in = res_status_ff;
      res_sx_in     = res_sx_ff;
      res_sy_in     = res_sy_ff;
      res_ex_in     = res_ex_ff;
      res_ey_in     = res_ey_ff;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_draw_in   = rsp_draw_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sx_in     = rsp_sx_ff;
      rsp_sy_in     = rsp_sy_ff;
      rsp_ex_in     = rsp_ex_ff;
      rsp_ey_in     = rsp_ey_ff;
      do_reject     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_chan.operation;
               ax_in    = pen_x_ff;
               ay_in    = pen_y_ff;
               bx_in    = tx;
               by_in    = ty;
               pen_x_in = tx;
               pen_y_in = ty;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ext_x_in = ext_x_new;
            ext_y_in = ext_y_new;
            rnd_x_in = mag_x[W:1];
            rnd_y_in = mag_y[W:1];
            px_in    = VW'(ax_ff);
            py_in    = VW'(ay_ff);
            ep_in       = 1'b0;
            clipped_in  = 1'b0;
            any_clip_in = 1'b0;
            if (!is_draw) begin
               // a move reports the new pen position
               res_draw_in   = 1'b0;
               res_status_in = plc_pkg::STATUS_UNCLIPPED;
               res_sx_in     = bx_ff;
               res_sy_in     = by_ff;
               res_ex_in     = bx_ff;
               res_ey_in     = by_ff;
               state_in      = S_DONE;
            end else if (trivial_out) begin
               do_reject = 1'b1;
            end else begin
               state_in = S_FX;
            end
         end
         // pull to an x edge first
         S_FX: begin
            if (!out_x) begin
               state_in = S_FY;
            end else if (ext_x_ff == '0) begin
               do_reject = 1'b1;
            end else begin
               px_in    = VW'(edge_x);
               sv_in    = edge_x;
               mode_in  = MODE_X;
               blk_in   = 1'b0;
               depth_in = 1'b0;
               state_in = S_MUL;
            end
         end
         // then to a y edge
         S_FY: begin
            if (!out_y) begin
               state_in = S_NEXT;
            end else if (ext_y_ff == '0) begin
               do_reject = 1'b1;
            end else begin
               py_in    = VW'(edge_y);
               sv_in    = edge_y;
               mode_in  = MODE_Y;
               blk_in   = 1'b1;
               depth_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = sol_prod;
            state_in = S_RND;
         end
         S_RND: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               if (mode_ff == MODE_X) py_in = sol_res;
               else                   px_in = sol_res;
               state_in = S_TEST;
            end
         end
         // check the solved coordinate, pull once more if needed
         S_TEST: begin
            if (!test_out) begin
               clipped_in = 1'b1;
               state_in   = blk_ff ? S_NEXT : S_FY;
            end else if (depth_ff) begin
               do_reject = 1'b1;
            end else if (test_y) begin
               if (ext_y_ff == '0) begin
                  do_reject = 1'b1;
               end else begin
                  py_in    = VW'(edge_y);
                  sv_in    = edge_y;
                  mode_in  = MODE_Y;
                  depth_in = 1'b1;
                  state_in = S_MUL;
               end
            end else begin
               if (ext_x_ff == '0) begin
                  do_reject = 1'b1;
               end else begin
                  px_in    = VW'(edge_x);
                  sv_in    = edge_x;
                  mode_in  = MODE_X;
                  depth_in = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         // endpoint finished: start the next or build the result
         S_NEXT: begin
            if (!ep_ff) begin
               fa_x_in     = px_ff[W-1:0];
               fa_y_in     = py_ff[W-1:0];
               any_clip_in = clipped_ff;
               clipped_in  = 1'b0;
               px_in       = VW'(bx_ff);
               py_in       = VW'(by_ff);
               ep_in       = 1'b1;
               state_in    = S_FX;
            end else begin
               res_draw_in   = 1'b1;
               res_status_in = (any_clip_ff || clipped_ff) ? plc_pkg::STATUS_PARTLY
                                                           : plc_pkg::STATUS_UNCLIPPED;
               res_sx_in     = fa_x_ff;
               res_sy_in     = fa_y_ff;
               res_ex_in     = px_ff[W-1:0];
               res_ey_in     = py_ff[W-1:0];
               state_in      = S_DONE;
            end
         end
         // hand the result to the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_draw_in   = res_draw_ff;
               rsp_status_in = res_status_ff;
               rsp_sx_in     = res_sx_ff;
               rsp_sy_in     = res_sy_ff;
               rsp_ex_in     = res_ex_ff;
               rsp_ey_in     = res_ey_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // rejected draws report the unclipped segment
      if (do_reject) begin
         res_draw_in   = 1'b0;
         res_status_in = plc_pkg::STATUS_REJECTED;
         res_sx_in     = ax_ff;
         res_sy_in     = ay_ff;
         res_ex_in     = bx_ff;
         res_ey_in     = by_ff;
         state_in      = S_DONE;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= W'(plc_pkg::CLIP_LEFT_RST);
         clip_right_ff  <= W'(plc_pkg::CLIP_RIGHT_RST);
         clip_top_ff    <= W'(plc_pkg::CLIP_TOP_RST);
         clip_bottom_ff <= W'(plc_pkg::CLIP_BOTTOM_RST);
      end else if (csr_xfer) begin
         unique case (csr_chan.index)
            plc_pkg::REG_CLIP_LEFT:   clip_left_ff   <= $signed(csr_chan.data);
            plc_pkg::REG_CLIP_RIGHT:  clip_right_ff  <= $signed(csr_chan.data);
            plc_pkg::REG_CLIP_TOP:    clip_top_ff    <= $signed(csr_chan.data);
            plc_pkg::REG_CLIP_BOTTOM: clip_bottom_ff <= $signed(csr_chan.data);
            default: ;
         endcase
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      ext_x_ff      <= ext_x_in;
      ext_y_ff      <= ext_y_in;
      rnd_x_ff      <= rnd_x_in;
      rnd_y_ff      <= rnd_y_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      sv_ff         <= sv_in;
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      depth_ff      <= depth_in;
      ep_ff         <= ep_in;
      clipped_ff    <= clipped_in;
      any_clip_ff   <= any_clip_in;
      fa_x_ff       <= fa_x_in;
      fa_y_ff       <= fa_y_in;
      prod_ff       <= prod_in;
      res_draw_ff   <= res_draw_in;
      res_status_ff <= res_status_in;
      res_sx_ff     <= res_sx_in;
      res_sy_ff     <= res_sy_in;
      res_ex_ff     <= res_ex_in;
      res_ey_ff     <= res_ey_in;
      rsp_draw_ff   <= rsp_draw_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sx_ff     <= rsp_sx_in;
      rsp_sy_ff     <= rsp_sy_in;
      rsp_ex_ff     <= rsp_ex_in;
      rsp_ey_ff     <= rsp_ey_in;
   end

   // response outputs
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.draw_valid  = rsp_draw_ff;
   assign rsp_chan.clip_status = rsp_status_ff;
   assign rsp_chan.start_x     = rsp_sx_ff;
   assign rsp_chan.start_y     = rsp_sy_ff;
   assign rsp_chan.end_x       = rsp_ex_ff;
   assign rsp_chan.end_y       = rsp_ey_ff;

   // checks
   a_draw_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_draw_ff) |-> (rsp_status_ff != plc_pkg::STATUS_REJECTED))
      else $error("rendered segment marked as rejected");

   a_move_is_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_draw_ff && rsp_status_ff == plc_pkg::STATUS_UNCLIPPED)
      |-> (rsp_sx_ff == rsp_ex_ff && rsp_sy_ff == rsp_ey_ff))
      else $error("move result with differing endpoints");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_chan.ready)
      else $error("request taken while an item is at work");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the wait state");

endmodule

[verif/tb_pen_line_clipper.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pen_line_clipper: a directed table, then random segments
// over several clip windows, checked against a behavioural clipper run in step.
// Depends on plc_pkg, the channel interfaces in plc_if.sv and the pen_line_clipper RTL.
module tb_pen_line_clipper;

   localparam int     CW           = plc_pkg::COORD_BITS_DEF;
   localparam int     CMAX         = (1 << (CW - 1)) - 1;
   localparam int     CMIN         = -CMAX - 1;
   localparam int     MAX_WAIT     = 18;
   localparam int     HOLD_AT      = 150;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     DRAIN_CYCLES = 20;
   localparam int     RANDOM_ITEMS = 1450;
   localparam int     PHASES       = 8;

   typedef struct packed {
      logic                 draw_valid;
      logic [1:0]           clip_status;
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } segment_type;

   typedef struct {
      logic [1:0]  op;
      int          x;
      int          y;
      bit          pinned;
      segment_type seg;
   } stim_row_type;

   logic clock;
   logic reset;

   plc_req_if #(.COORD_BITS(CW)) req_chan ();
   plc_rsp_if #(.COORD_BITS(CW)) rsp_chan ();
   plc_csr_if #(.COORD_BITS(CW)) csr_chan ();

   pen_line_clipper #(.COORD_BITS(CW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // behavioural copy of the block state
   longint pen_x, pen_y;
   longint win_left, win_right, win_top, win_bottom;
   longint seg_org_x, seg_org_y, seg_dx, seg_dy, half_dx, half_dy;

   segment_type  pending_segments[$];
   stim_row_type dir_rows[$];

   // typed-in expectation travelling with the request payload
   bit          row_pinned;
   segment_type row_seg;

   bit quiet;
   bit held_off;
   int mismatches;
   int n_moves, n_draws, n_partly, n_rejected, n_reg_writes;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamp(longint v);
      return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
   endfunction

   // other coordinate at v, rounding term takes the sign of the product
   function automatic longint solve_at(longint v, longint v0, longint w0, longint dv,
                                       longint dw, longint r);
      longint t;
      t = dw * (v - v0);
      if (t < 0) t -= r;
      else t += r;
      return w0 + t / dv;
   endfunction

   function automatic bit x_out(longint x);
      return x < win_left || x > win_right;
   endfunction

   function automatic bit y_out(longint y);
      return y < win_top || y > win_bottom;
   endfunction

   function automatic longint y_on_x(longint x);
      return solve_at(x, seg_org_x, seg_org_y, seg_dx, seg_dy, half_dx);
   endfunction

   function automatic longint x_on_y(longint y);
      return solve_at(y, seg_org_y, seg_org_x, seg_dy, seg_dx, half_dy);
   endfunction

   // -1 rejected, 0 left alone, 1 pulled onto the window
   function automatic int pull_in(inout longint px, inout longint py);
      int c;
      c = 0;
      if (x_out(px)) begin
         if (seg_dx == 0) return -1;
         px = px < win_left ? win_left : win_right;
         py = y_on_x(px);
         if (y_out(py)) begin
            if (seg_dy == 0) return -1;
            py = py < win_top ? win_top : win_bottom;
            px = x_on_y(py);
            if (x_out(px)) return -1;
         end
         c = 1;
      end
      if (y_out(py)) begin
         if (seg_dy == 0) return -1;
         py = py < win_top ? win_top : win_bottom;
         px = x_on_y(py);
         if (x_out(px)) begin
            if (seg_dx == 0) return -1;
            px = px < win_left ? win_left : win_right;
            py = y_on_x(px);
            if (y_out(py)) return -1;
         end
         c = 1;
      end
      return c;
   endfunction

   function automatic segment_type clip_segment(logic [1:0] op, logic signed [CW-1:0] cx,
                                                logic signed [CW-1:0] cy);
      longint      tx, ty, ax, ay, bx, by;
      int          r1, r2;
      segment_type res;
      res.draw_valid  = 1'b0;
      res.clip_status = plc_pkg::STATUS_UNCLIPPED;
      if (op == plc_pkg::OP_MOVE_REL || op == plc_pkg::OP_DRAW_REL) begin
         tx = clamp(pen_x + longint'(cx));
         ty = clamp(pen_y + longint'(cy));
      end else begin
         tx = longint'(cx);
         ty = longint'(cy);
      end
      ax = pen_x; ay = pen_y;
      bx = tx;    by = ty;
      pen_x = tx;
      pen_y = ty;

      if (op == plc_pkg::OP_MOVE_ABS || op == plc_pkg::OP_MOVE_REL) begin
         ax = tx; ay = ty;
      end else if ((ax < win_left && bx < win_left) || (ax > win_right && bx > win_right) ||
                   (ay < win_top && by < win_top) || (ay > win_bottom && by > win_bottom)) begin
         res.clip_status = plc_pkg::STATUS_REJECTED;
      end else begin
         seg_org_x = ax;      seg_org_y = ay;
         seg_dx    = bx - ax; seg_dy    = by - ay;
         half_dx   = seg_dx / 2;
         if (half_dx < 0) half_dx = -half_dx;
         half_dy   = seg_dy / 2;
         if (half_dy < 0) half_dy = -half_dy;
         r1 = pull_in(ax, ay);
         r2 = r1 < 0 ? -1 : pull_in(bx, by);
         if (r1 < 0 || r2 < 0) begin
            // rejected segments report the unclipped ends
            res.clip_status = plc_pkg::STATUS_REJECTED;
            ax = seg_org_x; ay = seg_org_y;
            bx = tx;        by = ty;
         end else begin
            res.draw_valid  = 1'b1;
            res.clip_status = (r1 != 0 || r2 != 0) ? plc_pkg::STATUS_PARTLY
                                                   : plc_pkg::STATUS_UNCLIPPED;
         end
      end
      res.start_x = CW'(clamp(ax));
      res.start_y = CW'(clamp(ay));
      res.end_x   = CW'(clamp(bx));
      res.end_y   = CW'(clamp(by));
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         pen_x      = 0;
         pen_y      = 0;
         win_left   = longint'(plc_pkg::CLIP_LEFT_RST);
         win_right  = longint'(plc_pkg::CLIP_RIGHT_RST);
         win_top    = longint'(plc_pkg::CLIP_TOP_RST);
         win_bottom = longint'(plc_pkg::CLIP_BOTTOM_RST);
      end else begin
         // register write transfer
         if (csr_chan.valid && csr_chan.ready) begin
            n_reg_writes++;
            case (csr_chan.index)
               plc_pkg::REG_CLIP_LEFT:   win_left   = longint'($signed(csr_chan.data));
               plc_pkg::REG_CLIP_RIGHT:  win_right  = longint'($signed(csr_chan.data));
               plc_pkg::REG_CLIP_TOP:    win_top    = longint'($signed(csr_chan.data));
               plc_pkg::REG_CLIP_BOTTOM: win_bottom = longint'($signed(csr_chan.data));
               default: ;
            endcase
         end
         // request transfer: predict, keeping a typed-in row result where given
         if (req_chan.valid && req_chan.ready) begin
            want = clip_segment(req_chan.operation, req_chan.coord_x, req_chan.coord_y);
            if (row_pinned) want = row_seg;
            pending_segments.push_back(want);
         end
         // response transfer
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_segments.size() == 0) begin
               $error("response transfer with no segment expected");
               mismatches++;
            end else begin
               want = pending_segments.pop_front();
               if (want.clip_status == plc_pkg::STATUS_REJECTED) n_rejected++;
               else if (want.clip_status == plc_pkg::STATUS_PARTLY) n_partly++;
               if (want.draw_valid || want.clip_status != plc_pkg::STATUS_UNCLIPPED)
                  n_draws++;
               check_field("draw_valid",  64'(want.draw_valid),   64'(rsp_chan.draw_valid));
               check_field("clip_status", 64'(want.clip_status),  64'(rsp_chan.clip_status));
               check_field("start_x",     64'($signed(want.start_x)), 64'(rsp_chan.start_x));
               check_field("start_y",     64'($signed(want.start_y)), 64'(rsp_chan.start_y));
               check_field("end_x",       64'($signed(want.end_x)),   64'(rsp_chan.end_x));
               check_field("end_y",       64'($signed(want.end_y)),   64'(rsp_chan.end_y));
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // one request transfer; valid stays high across back-to-back items
   task automatic send_item(logic [1:0] op, int x, int y, bit pinned, segment_type seg);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.coord_x   <= CW'(x);
      req_chan.coord_y   <= CW'(y);
      row_pinned         <= pinned;
      row_seg            <= seg;
      if (op == plc_pkg::OP_MOVE_ABS || op == plc_pkg::OP_MOVE_REL) n_moves++;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_reg(logic [plc_pkg::CSR_ADDR_BITS-1:0] idx, int value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= CW'(value);
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, let every expected segment come back, then let the block settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(int l, int r, int t, int b);
      write_reg(plc_pkg::REG_CLIP_LEFT, l);
      write_reg(plc_pkg::REG_CLIP_RIGHT, r);
      write_reg(plc_pkg::REG_CLIP_TOP, t);
      write_reg(plc_pkg::REG_CLIP_BOTTOM, b);
      // a write past the last register must leave the window alone
      write_reg(plc_pkg::CSR_ADDR_BITS'($urandom_range(plc_pkg::REG_CLIP_BOTTOM + 1,
                                                       2**plc_pkg::CSR_ADDR_BITS - 1)),
                $urandom_range(0, 2**CW - 1));
   endtask

   function automatic void add_row(logic [1:0] op, int x, int y, bit pinned = 1'b0,
                                   logic dv = 1'b0,
                                   logic [1:0] st = plc_pkg::STATUS_UNCLIPPED,
                                   int sx = 0, int sy = 0, int ex = 0, int ey = 0);
      stim_row_type row;
      row.op     = op;
      row.x      = x;
      row.y      = y;
      row.pinned = pinned;
      row.seg    = '{dv, st, CW'(sx), CW'(sy), CW'(ex), CW'(ey)};
      dir_rows.push_back(row);
   endfunction

   // coordinate around an edge pair, with some full-range and extreme values
   function automatic int pick_coord(int a, int b);
      int lo, hi, span;
      case ($urandom_range(0, 9))
         0, 1: return int'($signed(CW'($urandom_range(0, 2**CW - 1))));
         2: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
         default: begin
            lo   = a < b ? a : b;
            hi   = a < b ? b : a;
            span = (hi - lo) / 2 + 16;
            lo   = lo - span < CMIN ? CMIN : lo - span;
            hi   = hi + span > CMAX ? CMAX : hi + span;
            return lo + int'($urandom_range(0, hi - lo));
         end
      endcase
   endfunction

   // receiver: random stalls, and once a long hold-off so the block backs up
   initial begin
      int w, taken;
      taken = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) begin
            w        = HOLD_CYCLES;
            held_off = 1'b1;
         end else begin
            w = draw_gap();
         end
         if (w > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   end

   // main sequence
   initial begin
      int          l, r, t, b, x, y, n;
      logic [1:0]  op;
      segment_type none;
      none = '0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= plc_pkg::OP_MOVE_ABS;
      req_chan.coord_x   <= '0;
      req_chan.coord_y   <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= plc_pkg::REG_CLIP_LEFT;
      csr_chan.data      <= '0;
      row_pinned         <= 1'b0;
      row_seg            <= '0;
      quiet      = 1'b0;
      held_off   = 1'b0;
      mismatches = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table against the reset window 0..1023
      add_row(plc_pkg::OP_DRAW_ABS, 100, 200, 1, 1, plc_pkg::STATUS_UNCLIPPED, 0, 0, 100, 200);
      add_row(plc_pkg::OP_MOVE_ABS, CMAX, CMAX, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              CMAX, CMAX, CMAX, CMAX);
      add_row(plc_pkg::OP_MOVE_REL, 1, 1, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              CMAX, CMAX, CMAX, CMAX);
      add_row(plc_pkg::OP_MOVE_ABS, CMIN, CMIN, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              CMIN, CMIN, CMIN, CMIN);
      add_row(plc_pkg::OP_MOVE_REL, -1, CMIN, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              CMIN, CMIN, CMIN, CMIN);
      add_row(plc_pkg::OP_DRAW_ABS, -5, -5, 1, 0, plc_pkg::STATUS_REJECTED, CMIN, CMIN, -5, -5);
      add_row(plc_pkg::OP_DRAW_REL, 2000, 10);
      // vertical, wholly right of the window
      add_row(plc_pkg::OP_DRAW_ABS, 1995, 2000, 1, 0, plc_pkg::STATUS_REJECTED,
              1995, 5, 1995, 2000);
      add_row(plc_pkg::OP_MOVE_ABS, 500, -100, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              500, -100, 500, -100);
      // vertical crossing the window
      add_row(plc_pkg::OP_DRAW_ABS, 500, 2000);
      add_row(plc_pkg::OP_DRAW_REL, CMAX, 0, 1, 0, plc_pkg::STATUS_REJECTED,
              500, 2000, CMAX, 2000);
      add_row(plc_pkg::OP_MOVE_ABS, -300, 512);
      // horizontal crossing the window
      add_row(plc_pkg::OP_DRAW_ABS, 1500, 512);
      add_row(plc_pkg::OP_DRAW_REL, CMIN, CMIN);
      add_row(plc_pkg::OP_MOVE_ABS, 1023, 1023, 1, 0, plc_pkg::STATUS_UNCLIPPED,
              1023, 1023, 1023, 1023);
      add_row(plc_pkg::OP_DRAW_ABS, 0, 0, 1, 1, plc_pkg::STATUS_UNCLIPPED, 1023, 1023, 0, 0);
      add_row(plc_pkg::OP_DRAW_ABS, -1, 1024);
      add_row(plc_pkg::OP_DRAW_ABS, CMAX, CMIN);
      add_row(plc_pkg::OP_DRAW_REL, CMAX, CMAX, 1, 0, plc_pkg::STATUS_REJECTED,
              CMAX, CMIN, CMAX, -1);
      add_row(plc_pkg::OP_MOVE_REL, CMIN, 0, 1, 0, plc_pkg::STATUS_UNCLIPPED, -1, -1, -1, -1);
      add_row(plc_pkg::OP_DRAW_ABS, 2000, 3000);
      add_row(plc_pkg::OP_MOVE_ABS, -200, 900);
      // passes by the bottom-left corner without touching the window
      add_row(plc_pkg::OP_DRAW_ABS, 200, 1300, 1, 0, plc_pkg::STATUS_REJECTED,
              -200, 900, 200, 1300);
      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].pinned,
                   dir_rows[i].seg);
      wait_idle();

      // random phases, each under its own window
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin l = CMIN; r = CMAX; t = CMIN; b = CMAX; end
            1: begin l = CMAX; r = CMIN; t = CMAX; b = CMIN; end
            2: begin
               l = $urandom_range(0, 1000); r = l;
               t = $urandom_range(0, 1000); b = t;
            end
            3: begin
               r = int'($urandom_range(0, 2000)) - 1000; l = r + int'($urandom_range(1, 300));
               b = int'($urandom_range(0, 2000)) - 1000; t = b + int'($urandom_range(1, 300));
            end
            PHASES - 1: begin
               l = plc_pkg::CLIP_LEFT_RST; r = plc_pkg::CLIP_RIGHT_RST;
               t = plc_pkg::CLIP_TOP_RST;  b = plc_pkg::CLIP_BOTTOM_RST;
            end
            default: begin
               l = int'($urandom_range(0, 6000)) - 3000; r = l + int'($urandom_range(0, 2500));
               t = int'($urandom_range(0, 6000)) - 3000; b = t + int'($urandom_range(0, 2500));
               if ($urandom_range(0, 3) == 0) l = CMIN;
               if ($urandom_range(0, 3) == 0) b = CMAX;
            end
         endcase
         set_window(l, r, t, b);
         quiet = (p % 3 == 1);
         n = RANDOM_ITEMS / PHASES;
         for (int k = 0; k < n; k++) begin
            op = 2'($urandom_range(0, 3));
            if (op == plc_pkg::OP_MOVE_REL || op == plc_pkg::OP_DRAW_REL) begin
               if ($urandom_range(0, 3) == 0) begin
                  x = int'($signed(CW'($urandom_range(0, 2**CW - 1))));
                  y = int'($signed(CW'($urandom_range(0, 2**CW - 1))));
               end else begin
                  x = int'($urandom_range(0, 6000)) - 3000;
                  y = int'($urandom_range(0, 6000)) - 3000;
               end
            end else begin
               x = pick_coord(l, r);
               y = pick_coord(t, b);
            end
            send_item(op, x, y, 1'b0, none);
         end
         wait_idle();
      end

      $display("Ran %0d moves and %0d draws (%0d partly clipped, %0d rejected)",
               n_moves, n_draws, n_partly, n_rejected);
      $display("over %0d windows with %0d register writes; long response hold-off: %0d",
               PHASES + 1, n_reg_writes, held_off);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #15_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
